@@ rtl/ttc_speed_limiter_macros.svh @@
// ---------------------------------------------------------------------------
// ttc_speed_limiter_macros
// Assertion macros shared by the speed limiter RTL.
// ---------------------------------------------------------------------------
`ifndef TTC_SPEED_LIMITER_MACROS_SVH
`define TTC_SPEED_LIMITER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TTCSL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTCSL_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTCSL_ASSERT(label, clk, rst_n, prop, msg)
`define TTCSL_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

@@ rtl/ttcsl_pkg.sv @@
// ---------------------------------------------------------------------------
// ttcsl_pkg
// Types, widths and constants of the time-to-collision speed limiter.
// ---------------------------------------------------------------------------
`default_nettype none

package ttcsl_pkg;

    localparam int OPC_W      = 3;
    localparam int DIST_W     = 11;
    localparam int RANGE_W    = 10;
    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 15;
    localparam int ODIST_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int D4_W       = RANGE_W + 2;
    localparam int DEN_W      = 24;
    localparam int DVD_W      = D4_W + SAMPLE_W;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 10'd400;
    localparam logic [DEN_W-1:0]   SPEED_SCALE = 24'd400;

    localparam logic [THR_W-1:0]   FOCUS_RESET  = 15'd15360;
    localparam logic [THR_W-1:0]   STOP_RESET   = 15'd154;
    localparam logic [THR_W-1:0]   REDUCE_RESET = 15'd461;
    localparam logic [ODIST_W-1:0] ODIST_RESET  = 10'd60;
    localparam logic [TIME_W-1:0]  OWAIT_RESET  = 32'd2000000;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ODIST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OWAIT  = 3'd4;

    typedef enum logic [OPC_W-1:0] {
        OP_START = 3'd0,
        OP_ULTRA = 3'd1,
        OP_CMD   = 3'd2,
        OP_MEAS  = 3'd3,
        OP_STEER = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TTC_START,
        S_TTC_WAIT,
        S_BAND,
        S_RED_WAIT,
        S_CLOSE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [THR_W-1:0]   focus_threshold;
        logic [THR_W-1:0]   stop_ttc;
        logic [THR_W-1:0]   reduce_ttc;
        logic [ODIST_W-1:0] overtake_dist_cm;
        logic [TIME_W-1:0]  overtake_wait_us;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

@@ rtl/ttcsl_cfg.sv @@
// ---------------------------------------------------------------------------
// ttcsl_cfg
// Configuration register bank with write decode.
// ---------------------------------------------------------------------------
`default_nettype none

module ttcsl_cfg
    import ttcsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FOCUS:  cfg_next.focus_threshold  = cfg_data[THR_W-1:0];
                CFG_STOP:   cfg_next.stop_ttc         = cfg_data[THR_W-1:0];
                CFG_REDUCE: cfg_next.reduce_ttc       = cfg_data[THR_W-1:0];
                CFG_ODIST:  cfg_next.overtake_dist_cm = cfg_data[ODIST_W-1:0];
                CFG_OWAIT:  cfg_next.overtake_wait_us = cfg_data[TIME_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focus_threshold  <= FOCUS_RESET;
            cfg_reg.stop_ttc         <= STOP_RESET;
            cfg_reg.reduce_ttc       <= REDUCE_RESET;
            cfg_reg.overtake_dist_cm <= ODIST_RESET;
            cfg_reg.overtake_wait_us <= OWAIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/ttcsl_div.sv @@
// ---------------------------------------------------------------------------
// ttcsl_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ttcsl_div
    import ttcsl_pkg::*;
#(
    parameter int DVD_BITS = DVD_W,
    parameter int DVS_BITS = DEN_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_BITS-1:0] dividend,
    input  logic [DVS_BITS-1:0] divisor,
    output div_stat_t           stat,
    output logic [DVD_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_BITS + 1);

    logic [DVS_BITS-1:0] rem_reg, rem_next;
    logic [DVD_BITS-1:0] quo_reg, quo_next;
    logic [DVS_BITS-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DVS_BITS:0]   trial;
    logic                fits;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DVD_BITS-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        if (start && !busy_reg)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = DVS_BITS'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[DVS_BITS-1:0];
            end
            quo_next = {quo_reg[DVD_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

@@ rtl/ttc_speed_limiter.sv @@
// ---------------------------------------------------------------------------
// ttc_speed_limiter
// Event-driven speed limiter based on time to collision, Q8.8 arithmetic.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    opcode .. time_us
//   out      source     out_valid/out_ready  send .. overtake_event
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// Start, ultrasonic and speed transactions go from S_IDLE to S_OUT.
// Running steering transactions take S_TTC_START, S_TTC_WAIT, S_BAND,
// S_RED_WAIT, S_CLOSE, S_OUT as needed; both waits share the 28-step divider.
// One transaction at a time; the result register lets the next one in
// while a result waits. Control state resets on rst_n; datapath does not.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ttc_speed_limiter_macros.svh"

module ttc_speed_limiter
    import ttcsl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OPC_W-1:0]           opcode,
    input  logic                       start_flag,
    input  logic signed [DIST_W-1:0]   dist_center,
    input  logic signed [DIST_W-1:0]   dist_left,
    input  logic signed [DIST_W-1:0]   dist_right,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic [TIME_W-1:0]          time_us,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       send,
    output logic signed [SAMPLE_W-1:0] accel_out,
    output logic signed [SAMPLE_W-1:0] steer_out,
    output logic                       overtake_req,
    output logic                       overtake_event,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    cfg_t      cfg;
    div_stat_t div_stat;
    logic [DVD_W-1:0] div_quo;
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DEN_W-1:0] div_dvs;

    state_t state_reg, state_next;
    logic                run_enable_reg, run_enable_next;
    logic [RANGE_W-1:0]  range_center_reg, range_center_next;
    logic [RANGE_W-1:0]  range_left_reg, range_left_next;
    logic [RANGE_W-1:0]  range_right_reg, range_right_next;
    logic [SAMPLE_W-1:0] speed_command_reg, speed_command_next;
    logic [SAMPLE_W-1:0] speed_measured_reg, speed_measured_next;
    logic [SAMPLE_W-1:0] accel_hold_reg, accel_hold_next;
    logic [SAMPLE_W-1:0] steer_hold_reg, steer_hold_next;
    logic                block_timing_reg, block_timing_next;
    logic [TIME_W-1:0]   block_start_reg, block_start_next;
    logic                overtake_latch_reg, overtake_latch_next;
    logic                send_reg, send_next;
    logic                fire_reg, fire_next;
    logic                out_valid_reg, out_valid_next;

    logic [D4_W-1:0]     d4_reg, d4_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic                neg_reg, neg_next;
    logic                out_send_reg, out_send_next;
    logic [SAMPLE_W-1:0] out_accel_reg, out_accel_next;
    logic [SAMPLE_W-1:0] out_steer_reg, out_steer_next;
    logic                out_req_reg, out_req_next;
    logic                out_event_reg, out_event_next;

    logic signed [SAMPLE_W:0] samp_ext;
    logic signed [SAMPLE_W:0] thr_ext;
    logic                     right_sel;
    logic                     left_sel;
    logic [RANGE_W-1:0]       side_range;
    logic [D4_W-1:0]          d4_calc;
    logic                     spd_zero;
    logic                     spd_neg;
    logic [SAMPLE_W+1:0]      red_diff;
    logic [SAMPLE_W+1:0]      red_abs;
    logic [SAMPLE_W-1:0]      red_sat;
    logic [TIME_W-1:0]        elapsed;

    ttcsl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ttcsl_div #(
        .DVD_BITS (DVD_W),
        .DVS_BITS (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb
    begin
        samp_ext   = {sample_value[SAMPLE_W-1], sample_value};
        thr_ext    = {2'b00, cfg.focus_threshold};
        right_sel  = (samp_ext > thr_ext);
        left_sel   = (samp_ext < -thr_ext);
        side_range = right_sel ? range_right_reg : range_left_reg;
        if (right_sel || left_sel)
        begin
            d4_calc = {2'b00, range_center_reg} + {2'b00, side_range}
                    + {1'b0, side_range, 1'b0};
        end
        else
        begin
            d4_calc = {range_center_reg, 2'b00};
        end

        spd_zero = (speed_measured_reg == '0);
        spd_neg  = speed_measured_reg[SAMPLE_W-1];

        red_diff = {{2{speed_command_reg[SAMPLE_W-1]}}, speed_command_reg}
                 - {3'b000, cfg.stop_ttc};
        red_abs  = red_diff[SAMPLE_W+1] ? (~red_diff + 1'b1) : red_diff;

        if (!neg_reg)
        begin
            if (|div_quo[DVD_W-1:SAMPLE_W-1])
            begin
                red_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
            end
            else
            begin
                red_sat = {1'b0, div_quo[SAMPLE_W-2:0]};
            end
        end
        else
        begin
            if (div_quo > DVD_W'(32768))
            begin
                red_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
            end
            else
            begin
                red_sat = ~div_quo[SAMPLE_W-1:0] + 1'b1;
            end
        end

        elapsed = now_reg - block_start_reg;
    end

    always_comb
    begin
        state_next          = state_reg;
        run_enable_next     = run_enable_reg;
        range_center_next   = range_center_reg;
        range_left_next     = range_left_reg;
        range_right_next    = range_right_reg;
        speed_command_next  = speed_command_reg;
        speed_measured_next = speed_measured_reg;
        accel_hold_next     = accel_hold_reg;
        steer_hold_next     = steer_hold_reg;
        block_timing_next   = block_timing_reg;
        block_start_next    = block_start_reg;
        overtake_latch_next = overtake_latch_reg;
        send_next           = send_reg;
        fire_next           = fire_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        d4_next             = d4_reg;
        den_next            = den_reg;
        now_next            = now_reg;
        neg_next            = neg_reg;
        out_send_next       = out_send_reg;
        out_accel_next      = out_accel_reg;
        out_steer_next      = out_steer_reg;
        out_req_next        = out_req_reg;
        out_event_next      = out_event_reg;
        div_start           = 1'b0;
        div_dvd             = {d4_reg, {SAMPLE_W{1'b0}}};
        div_dvs             = den_reg;
        in_ready            = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    fire_next  = 1'b0;
                    state_next = S_OUT;
                    case (opcode)
                        OP_START:
                        begin
                            run_enable_next = start_flag;
                            if (!start_flag)
                            begin
                                accel_hold_next = '0;
                                steer_hold_next = '0;
                            end
                            send_next = 1'b1;
                        end
                        OP_ULTRA:
                        begin
                            if (!dist_center[DIST_W-1] && |dist_center[RANGE_W-1:0])
                            begin
                                range_center_next = dist_center[RANGE_W-1:0];
                            end
                            if (!dist_left[DIST_W-1] && |dist_left[RANGE_W-1:0])
                            begin
                                range_left_next = dist_left[RANGE_W-1:0];
                            end
                            if (!dist_right[DIST_W-1] && |dist_right[RANGE_W-1:0])
                            begin
                                range_right_next = dist_right[RANGE_W-1:0];
                            end
                            send_next = run_enable_reg;
                        end
                        OP_CMD:
                        begin
                            speed_command_next = sample_value;
                            send_next          = run_enable_reg;
                        end
                        OP_MEAS:
                        begin
                            speed_measured_next = sample_value;
                            send_next           = run_enable_reg;
                        end
                        OP_STEER:
                        begin
                            if (!run_enable_reg)
                            begin
                                accel_hold_next     = '0;
                                steer_hold_next     = '0;
                                overtake_latch_next = 1'b0;
                                send_next           = 1'b0;
                            end
                            else
                            begin
                                steer_hold_next = sample_value;
                                d4_next         = d4_calc;
                                den_next        = {9'd0, speed_measured_reg[SAMPLE_W-2:0]}
                                                * SPEED_SCALE;
                                now_next        = time_us;
                                state_next      = S_TTC_START;
                            end
                        end
                        default:
                        begin
                            send_next = 1'b0;
                        end
                    endcase
                end
            end

            S_TTC_START:
            begin
                if (spd_zero || spd_neg)
                begin
                    state_next = S_BAND;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_TTC_WAIT;
                end
            end

            S_TTC_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_BAND;
                end
            end

            S_BAND:
            begin
                state_next = S_CLOSE;
                if (spd_zero || (!spd_neg && div_quo > DVD_W'(cfg.reduce_ttc)))
                begin
                    accel_hold_next = speed_command_reg;
                end
                else if (!spd_neg && div_quo >= DVD_W'(cfg.stop_ttc))
                begin
                    if (cfg.reduce_ttc > cfg.stop_ttc)
                    begin
                        div_start  = 1'b1;
                        div_dvd    = {3'b000, red_abs[SAMPLE_W:0], 8'h00};
                        div_dvs    = DEN_W'(cfg.reduce_ttc - cfg.stop_ttc);
                        neg_next   = red_diff[SAMPLE_W+1];
                        state_next = S_RED_WAIT;
                    end
                    else
                    begin
                        accel_hold_next = '0;
                    end
                end
                else
                begin
                    accel_hold_next = '0;
                    steer_hold_next = '0;
                end
            end

            S_RED_WAIT:
            begin
                if (div_stat.done)
                begin
                    accel_hold_next = red_sat;
                    state_next      = S_CLOSE;
                end
            end

            S_CLOSE:
            begin
                send_next  = 1'b1;
                state_next = S_OUT;
                if (d4_reg < {cfg.overtake_dist_cm, 2'b00})
                begin
                    accel_hold_next = '0;
                    steer_hold_next = '0;
                    if (!block_timing_reg)
                    begin
                        block_start_next  = now_reg;
                        block_timing_next = 1'b1;
                    end
                    else if (elapsed > cfg.overtake_wait_us)
                    begin
                        run_enable_next     = 1'b0;
                        block_timing_next   = 1'b0;
                        overtake_latch_next = 1'b1;
                        fire_next           = 1'b1;
                    end
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_send_next  = send_reg;
                    out_accel_next = accel_hold_reg;
                    out_steer_next = steer_hold_reg;
                    out_req_next   = overtake_latch_reg;
                    out_event_next = fire_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            run_enable_reg     <= 1'b0;
            range_center_reg   <= RANGE_RESET;
            range_left_reg     <= RANGE_RESET;
            range_right_reg    <= RANGE_RESET;
            speed_command_reg  <= '0;
            speed_measured_reg <= '0;
            accel_hold_reg     <= '0;
            steer_hold_reg     <= '0;
            block_timing_reg   <= 1'b0;
            block_start_reg    <= '0;
            overtake_latch_reg <= 1'b0;
            send_reg           <= 1'b0;
            fire_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            run_enable_reg     <= run_enable_next;
            range_center_reg   <= range_center_next;
            range_left_reg     <= range_left_next;
            range_right_reg    <= range_right_next;
            speed_command_reg  <= speed_command_next;
            speed_measured_reg <= speed_measured_next;
            accel_hold_reg     <= accel_hold_next;
            steer_hold_reg     <= steer_hold_next;
            block_timing_reg   <= block_timing_next;
            block_start_reg    <= block_start_next;
            overtake_latch_reg <= overtake_latch_next;
            send_reg           <= send_next;
            fire_reg           <= fire_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d4_reg        <= d4_next;
        den_reg       <= den_next;
        now_reg       <= now_next;
        neg_reg       <= neg_next;
        out_send_reg  <= out_send_next;
        out_accel_reg <= out_accel_next;
        out_steer_reg <= out_steer_next;
        out_req_reg   <= out_req_next;
        out_event_reg <= out_event_next;
    end

    assign out_valid      = out_valid_reg;
    assign send           = out_send_reg;
    assign accel_out      = out_accel_reg;
    assign steer_out      = out_steer_reg;
    assign overtake_req   = out_req_reg;
    assign overtake_event = out_event_reg;

    `TTCSL_ASSERT(a_accept_blocks, clk, rst_n, in_valid && in_ready |=> !in_ready, "accepted transaction did not block input")
    `TTCSL_ASSERT(a_div_free, clk, rst_n, div_start |-> !div_stat.busy, "divider started while busy")
    `TTCSL_ASSERT(a_event_latched, clk, rst_n, out_valid && overtake_event |-> overtake_req, "overtake event without request level")
    `TTCSL_ASSERT(a_fire_stops, clk, rst_n, $rose(overtake_latch_reg) |-> !run_enable_reg && !block_timing_reg, "overtake fired while still running")
    `TTCSL_ASSERT_NR(a_idle_div, clk, in_ready |-> !div_stat.busy, "divider busy while idle")

endmodule

`default_nettype wire
